// File: src/bsfc_pkg.sv
// shared types, constants and helper functions of the balance controller
`default_nettype none

package bsfc_pkg;

  typedef enum logic {
    CmdCalib   = 1'b0,
    CmdControl = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    RegGyroZero       = 3'd0,
    RegGainTiltAngle  = 3'd1,
    RegGainTiltRate   = 3'd2,
    RegGainWheelAngle = 3'd3,
    RegGainWheelSpeed = 3'd4,
    RegGainErrorSum   = 3'd5,
    RegSteering       = 3'd6,
    RegAngleReference = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  gyro_zero;
    logic [15:0] gain_tilt_angle;
    logic [15:0] gain_tilt_rate;
    logic [15:0] gain_wheel_angle;
    logic [15:0] gain_wheel_speed;
    logic [15:0] gain_error_sum;
    logic [8:0]  steering;
    logic [15:0] angle_reference;
  } cfg_t;

  typedef struct packed {
    logic [33:0] rate;
    logic [31:0] tilt;
    logic [16:0] err;
    logic [16:0] speed;
    logic [31:0] esum;
  } op_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [9:0]  GyroZeroRst       = 10'd585;
  localparam logic [15:0] GainTiltAngleRst  = 16'd45;
  localparam logic [15:0] GainTiltRateRst   = 16'd10;
  localparam logic [15:0] GainWheelAngleRst = 16'd200;
  localparam logic [15:0] GainWheelSpeedRst = 16'd500;
  localparam logic [15:0] GainErrorSumRst   = 16'd0;

  localparam int unsigned GyroShift = 4;
  localparam int unsigned RateShift = 3;
  localparam int unsigned TiltShift = 4;
  localparam logic signed [55:0] Deadband = 56'sd5;

  localparam int unsigned DutyDiv   = 100;
  localparam int unsigned DutyLog   = $clog2(DutyDiv);
  localparam int unsigned DutyShift = 32 + DutyLog;
  localparam logic [64:0] DutyNum   = 65'd1 << DutyShift;
  localparam logic [32:0] DutyMagic =
    33'((DutyNum + 65'(DutyDiv) - 65'd1) / 65'(DutyDiv));

  localparam logic signed [27:0] PowerMax = 28'sd255;

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -56'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [8:0] clamp_power(input logic signed [27:0] v);
    logic signed [8:0] r;
    if (v > PowerMax) begin
      r = 9'sd255;
    end else if (v < -PowerMax) begin
      r = -9'sd255;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/bsfc_cfg.sv
// configuration register file of the balance controller
`default_nettype none

module bsfc_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bsfc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [bsfc_pkg::CfgDataW-1:0]     cfg_data_i,
  output bsfc_pkg::cfg_t                         cfg_o
);

  bsfc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_zero        <= bsfc_pkg::GyroZeroRst;
      cfg_q.gain_tilt_angle  <= bsfc_pkg::GainTiltAngleRst;
      cfg_q.gain_tilt_rate   <= bsfc_pkg::GainTiltRateRst;
      cfg_q.gain_wheel_angle <= bsfc_pkg::GainWheelAngleRst;
      cfg_q.gain_wheel_speed <= bsfc_pkg::GainWheelSpeedRst;
      cfg_q.gain_error_sum   <= bsfc_pkg::GainErrorSumRst;
      cfg_q.steering         <= '0;
      cfg_q.angle_reference  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bsfc_pkg::reg_idx_e'(cfg_index_i))
        bsfc_pkg::RegGyroZero:       cfg_q.gyro_zero        <= cfg_data_i[9:0];
        bsfc_pkg::RegGainTiltAngle:  cfg_q.gain_tilt_angle  <= cfg_data_i;
        bsfc_pkg::RegGainTiltRate:   cfg_q.gain_tilt_rate   <= cfg_data_i;
        bsfc_pkg::RegGainWheelAngle: cfg_q.gain_wheel_angle <= cfg_data_i;
        bsfc_pkg::RegGainWheelSpeed: cfg_q.gain_wheel_speed <= cfg_data_i;
        bsfc_pkg::RegGainErrorSum:   cfg_q.gain_error_sum   <= cfg_data_i;
        bsfc_pkg::RegSteering:       cfg_q.steering         <= cfg_data_i[8:0];
        bsfc_pkg::RegAngleReference: cfg_q.angle_reference  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bsfc_duty.sv
// duty sum pipeline: gain products, sum, saturation with deadband, motor powers
`default_nettype none

module bsfc_duty (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bsfc_pkg::cfg_t      cfg_i,
  input  wire logic                op_valid_i,
  input  wire bsfc_pkg::op_t       op_i,
  output logic                     adv_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [8:0]        power_a_o,
  output logic signed [8:0]        power_c_o,
  output logic signed [31:0]       duty_sum_o
);

  localparam int unsigned SumW = 54;

  logic adv;
  logic s2_v_q, s3_v_q, s4_v_q, out_v_q;

  // product stage
  logic signed [16:0] g_tilt, g_rate, g_err, g_speed, g_esum;
  logic signed [31:0] x_tilt, x_esum;
  logic signed [33:0] x_rate;
  logic signed [16:0] x_err, x_speed;
  logic signed [48:0] p_tilt_d, p_tilt_q, p_esum_d, p_esum_q;
  logic signed [50:0] p_rate_d, p_rate_q;
  logic signed [33:0] p_err_d, p_err_q, p_speed_d, p_speed_q;

  // sum stage
  logic signed [50:0]     rate8;
  logic signed [SumW-1:0] sum_d, sum_q;

  // saturation stage
  logic signed [31:0] sat;
  logic signed [31:0] duty_d, duty_q;

  // power stage
  logic               neg;
  logic [31:0]        mag;
  logic [64:0]        prod;
  logic [25:0]        quot;
  logic signed [26:0] base;
  logic signed [27:0] sum_a, sum_c, steer;
  logic signed [8:0]  pa_d, pa_q, pc_d, pc_q;
  logic signed [31:0] dout_q;

  assign adv   = !out_v_q || out_ready_i;
  assign adv_o = adv;

  assign g_tilt  = $signed({1'b0, cfg_i.gain_tilt_angle});
  assign g_rate  = $signed({1'b0, cfg_i.gain_tilt_rate});
  assign g_err   = $signed({1'b0, cfg_i.gain_wheel_angle});
  assign g_speed = $signed({1'b0, cfg_i.gain_wheel_speed});
  assign g_esum  = $signed({1'b0, cfg_i.gain_error_sum});
  assign x_tilt  = $signed(op_i.tilt);
  assign x_rate  = $signed(op_i.rate);
  assign x_err   = $signed(op_i.err);
  assign x_speed = $signed(op_i.speed);
  assign x_esum  = $signed(op_i.esum);

  assign p_tilt_d  = 49'(g_tilt) * 49'(x_tilt);
  assign p_rate_d  = 51'(g_rate) * 51'(x_rate);
  assign p_err_d   = 34'(g_err) * 34'(x_err);
  assign p_speed_d = 34'(g_speed) * 34'(x_speed);
  assign p_esum_d  = 49'(g_esum) * 49'(x_esum);

  // truncate toward zero
  assign rate8 = (p_rate_q + (p_rate_q[50] ? 51'sd7 : 51'sd0)) >>> bsfc_pkg::RateShift;
  assign sum_d = SumW'(p_tilt_q) + SumW'(rate8) + SumW'(p_err_q)
               + SumW'(p_speed_q) + SumW'(p_esum_q);

  assign sat = bsfc_pkg::sat32(56'(sum_q));

  always_comb begin
    if (sat > 32'sd0) begin
      duty_d = bsfc_pkg::sat32(56'(sat) + bsfc_pkg::Deadband);
    end else if (sat < 32'sd0) begin
      duty_d = bsfc_pkg::sat32(56'(sat) - bsfc_pkg::Deadband);
    end else begin
      duty_d = '0;
    end
  end

  assign neg   = duty_q[31];
  assign mag   = neg ? (~duty_q + 32'd1) : duty_q;
  assign prod  = 65'(mag) * 65'(bsfc_pkg::DutyMagic);
  assign quot  = 26'(prod >> bsfc_pkg::DutyShift);
  assign base  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign steer = 28'($signed(cfg_i.steering));
  assign sum_a = 28'(base) + steer;
  assign sum_c = 28'(base) - steer;
  assign pa_d  = bsfc_pkg::clamp_power(sum_a);
  assign pc_d  = bsfc_pkg::clamp_power(sum_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q  <= op_valid_i;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_tilt_q  <= p_tilt_d;
      p_rate_q  <= p_rate_d;
      p_err_q   <= p_err_d;
      p_speed_q <= p_speed_d;
      p_esum_q  <= p_esum_d;
      sum_q     <= sum_d;
      duty_q    <= duty_d;
      pa_q      <= pa_d;
      pc_q      <= pc_d;
      dout_q    <= duty_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign power_a_o   = pa_q;
  assign power_c_o   = pc_q;
  assign duty_sum_o  = dout_q;

endmodule

`default_nettype wire

// File: src/balance_state_feedback_controller.sv
// top level of the two-wheel balance state-feedback controller
// Accepts one transaction per clock when not stalled. A control tick gives one result
// after passing the input register, state/operand stage, gain products, sum,
// saturation with deadband, then the divide by 100 and power clamp in the output
// register; a calibration sample gives none. The sample that completes a
// calibration round holds the input while the offset divide (one 32x33
// reciprocal multiply) writes the new rate offset. Back pressure on the
// result side stalls the whole pipeline; no reset clearing pass is needed.
`default_nettype none

module balance_state_feedback_controller #(
  parameter int unsigned HISTORY_DEPTH       = 5,
  parameter int unsigned CALIBRATION_SAMPLES = 50
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bsfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bsfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [9:0]                    gyro_raw_i,
  input  wire logic signed [15:0]            wheel_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [8:0]                  power_a_o,
  output logic signed [8:0]                  power_c_o,
  output logic signed [31:0]                 duty_sum_o
);

  localparam int unsigned HistW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CalLog   = $clog2(CALIBRATION_SAMPLES);
  localparam int unsigned CalShift = 32 + CalLog;
  localparam logic [64:0] CalNum   = 65'd1 << CalShift;
  localparam logic [32:0] CalMagic =
    33'((CalNum + 65'(CALIBRATION_SAMPLES) - 65'd1) / 65'(CALIBRATION_SAMPLES));
  localparam logic [5:0]  CalLast  = 6'(CALIBRATION_SAMPLES);
  localparam logic [HistW-1:0] HistLast = HistW'(HISTORY_DEPTH - 1);

  bsfc_pkg::cfg_t cfg;
  bsfc_pkg::op_t  op_d, op_q;
  logic           op_v_q;
  logic           adv;

  // input register
  logic               s0_v_q;
  logic               cmd_q;
  logic [9:0]         gyro_q;
  logic signed [15:0] wheel_q;
  logic               s0_go, proc, do_cal, do_ctl;

  // state
  logic signed [31:0] calib_sum_q, rate_offset_q, tilt_q, esum_q;
  logic [5:0]         calib_cnt_q;
  logic signed [15:0] hist_q [HISTORY_DEPTH];
  logic [HistW-1:0]   hidx_q;
  logic               cal_pend_q, fin_neg_q;
  logic [31:0]        fin_mag_q;

  logic signed [10:0] gdiff;
  logic signed [14:0] scaled;
  logic signed [31:0] calib_sum_d;
  logic [5:0]         calib_cnt_d;
  logic signed [33:0] rate, rate16;
  logic signed [15:0] angle, href;
  logic signed [16:0] err, speed;
  logic [64:0]        cal_prod;
  logic [31:0]        cal_quot;
  logic signed [31:0] rate_offset_d;

  bsfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s0_go      = adv && !cal_pend_q;
  assign in_ready_o = s0_go;
  assign proc       = s0_go && s0_v_q;
  assign do_cal     = proc && (cmd_q == bsfc_pkg::CmdCalib);
  assign do_ctl     = proc && (cmd_q == bsfc_pkg::CmdControl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_go) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_go) begin
      cmd_q   <= cmd_i;
      gyro_q  <= gyro_raw_i;
      wheel_q <= wheel_count_i;
    end
  end

  assign gdiff  = $signed({1'b0, gyro_q}) - $signed({1'b0, cfg.gyro_zero});
  assign scaled = 15'(gdiff) <<< bsfc_pkg::GyroShift;

  assign calib_sum_d = bsfc_pkg::sat32(56'(calib_sum_q) + 56'(scaled));
  assign calib_cnt_d = calib_cnt_q + 6'd1;

  assign rate   = 34'(scaled) - 34'(rate_offset_q);
  assign rate16 = (rate + (rate[33] ? 34'sd15 : 34'sd0)) >>> bsfc_pkg::TiltShift;
  // most negative count saturates
  assign angle  = (wheel_q == 16'sh8000) ? 16'sh7fff : -wheel_q;
  assign href   = $signed(cfg.angle_reference);
  assign err    = 17'(angle) - 17'(href);
  assign speed  = 17'(angle) - 17'(hist_q[hidx_q]);

  assign op_d.rate  = rate;
  assign op_d.tilt  = tilt_q;
  assign op_d.err   = err;
  assign op_d.speed = speed;
  assign op_d.esum  = esum_q;

  // offset divide, in the cycle after a round completes
  assign cal_prod      = 65'(fin_mag_q) * 65'(CalMagic);
  assign cal_quot      = 32'(cal_prod >> CalShift);
  assign rate_offset_d = fin_neg_q ? (~cal_quot + 32'd1) : cal_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_sum_q   <= '0;
      calib_cnt_q   <= '0;
      rate_offset_q <= '0;
      tilt_q        <= '0;
      esum_q        <= '0;
      hidx_q        <= '0;
      cal_pend_q    <= 1'b0;
      op_v_q        <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      cal_pend_q <= 1'b0;
      if (cal_pend_q) begin
        rate_offset_q <= rate_offset_d;
      end
      if (adv) begin
        op_v_q <= do_ctl;
      end
      if (do_cal) begin
        if (calib_cnt_d == CalLast) begin
          calib_sum_q <= '0;
          calib_cnt_q <= '0;
          cal_pend_q  <= 1'b1;
        end else begin
          calib_sum_q <= calib_sum_d;
          calib_cnt_q <= calib_cnt_d;
        end
      end
      if (do_ctl) begin
        tilt_q         <= bsfc_pkg::sat32(56'(tilt_q) + 56'(rate16));
        esum_q         <= bsfc_pkg::sat32(56'(esum_q) + 56'(err));
        hist_q[hidx_q] <= angle;
        hidx_q         <= (hidx_q == HistLast) ? '0 : hidx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q <= op_d;
    end
    if (do_cal) begin
      fin_neg_q <= calib_sum_d[31];
      fin_mag_q <= calib_sum_d[31] ? (~calib_sum_d + 32'd1) : calib_sum_d;
    end
  end

  bsfc_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (op_v_q),
    .op_i        (op_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .power_a_o   (power_a_o),
    .power_c_o   (power_c_o),
    .duty_sum_o  (duty_sum_o)
  );

  a_pend_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_pend_q |=> !cal_pend_q)
    else $error("offset divide pending for more than one cycle");

  a_pend_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_pend_q |-> (!in_ready_o && !do_cal && !do_ctl))
    else $error("transaction processed during offset divide");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calib_cnt_q < CalLast)
    else $error("calibration count passed the round length");

  a_hidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hidx_q <= HistLast)
    else $error("history index out of range");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (power_a_o != 9'h100 && power_c_o != 9'h100))
    else $error("motor power outside saturation range");

endmodule

`default_nettype wire
